@@ src/ic3_pkg.sv @@
// shared types, register and kernel codes, and the per-channel 3x3 filter function
// no dependencies
package ic3_pkg;

  typedef struct packed {
    logic       drain;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic [7:0] out3;
    logic       frame_end;
  } pixel_out_t;

  typedef logic [8:0][7:0] taps_t;

  localparam int CFG_W = 13;

  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] REG_KERNEL_SELECT = 2'd3;

  localparam logic [2:0] KERN_EDGE     = 3'd0;
  localparam logic [2:0] KERN_SHARPEN  = 3'd1;
  localparam logic [2:0] KERN_BOX      = 3'd2;
  localparam logic [2:0] KERN_GAUSS    = 3'd3;
  localparam logic [2:0] KERN_EMBOSS   = 3'd4;
  localparam logic [2:0] KERN_IDENTITY = 3'd5;

  localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [CFG_W-1:0] ROW_LIMIT    = 13'd8191;

  // weighted sum (box scaled by 114/1024, gauss divided by 16), then clamped to 0..255
  function automatic logic [7:0] filter_tap(logic [2:0] kern, taps_t p);
    logic signed [19:0] x [9];
    logic signed [19:0] acc;
    logic [7:0]         res;
    for (int i = 0; i < 9; i++) begin
      x[i] = signed'({12'd0, p[i]});
    end
    case (kern)
      KERN_EDGE: begin
        acc = 20'sd4 * x[4] - x[1] - x[3] - x[5] - x[7];
      end
      KERN_SHARPEN: begin
        acc = 20'sd5 * x[4] - x[1] - x[3] - x[5] - x[7];
      end
      KERN_BOX: begin
        acc = ((x[0] + x[1] + x[2] + x[3] + x[4] + x[5] + x[6] + x[7] + x[8])
               * 20'sd114) >>> 10;
      end
      KERN_GAUSS: begin
        acc = ((x[0] + x[2] + x[6] + x[8])
               + 20'sd2 * (x[1] + x[3] + x[5] + x[7])
               + 20'sd4 * x[4]) >>> 4;
      end
      KERN_EMBOSS: begin
        acc = x[4] + x[5] + x[7] + 20'sd2 * x[8] - 20'sd2 * x[0] - x[1] - x[3];
      end
      default: begin
        acc = x[4];
      end
    endcase
    if (acc <= 20'sd0) begin
      res = 8'd0;
    end else if (acc > 20'sd255) begin
      res = 8'd255;
    end else begin
      res = acc[7:0];
    end
    return res;
  endfunction

endpackage

@@ src/image_convolution_3x3_core.sv @@
// 3x3 convolution over a raster pixel stream, two line stores and a 3x3 window; uses ic3_pkg
// throughput: one transaction per clock unless pixel_stall; each line store is read every
//   cycle and written on each accepted transaction; a result passes the neighborhood and
//   output registers; results trail the input stream by image_width+1 transactions
// reset: synchronous; loads config defaults; clears counters, window and pipeline
//   valids; line stores keep their contents
module image_convolution_3x3_core #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pixel_valid,
  output logic                       pixel_stall,
  input  ic3_pkg::pixel_in_t         pixel,
  output logic                       result_valid,
  input  logic                       result_stall,
  output ic3_pkg::pixel_out_t        result,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [ic3_pkg::CFG_W-1:0]  cfg_data
);
  import ic3_pkg::*;

  localparam int PIX_W = 8 * MAX_CHANNELS;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int TOT_W = (WW + CFG_W > 25) ? WW + CFG_W : 25;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [2:0]       channel_count;
  logic [2:0]       kernel_select;

  logic [WW-1:0]    eff_w;
  logic [CFG_W-1:0] eff_h;

  logic [COL_W-1:0] in_column;
  logic [CFG_W-1:0] in_row;
  logic [23:0]      out_count;
  logic [PIX_W-1:0] win [9];

  logic [PIX_W-1:0] above_mem   [MAX_WIDTH];
  logic [PIX_W-1:0] current_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_above;
  logic [PIX_W-1:0] rd_current;
  logic             fwd;
  logic [PIX_W-1:0] fwd_above;
  logic [PIX_W-1:0] fwd_current;

  logic             accept;
  logic [PIX_W-1:0] a_pix;
  logic [PIX_W-1:0] b_pix;
  logic [PIX_W-1:0] v_pix;
  logic [PIX_W-1:0] top_pix;
  logic [31:0]      in_chans;
  logic [PIX_W-1:0] newcol [3];
  logic [PIX_W-1:0] nb [9];
  logic             emit;
  logic             last;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] count_inc;
  logic [WW-1:0]    col_inc;
  logic             col_wrap;
  logic [COL_W-1:0] col_next;
  logic [CFG_W-1:0] row_next;
  logic [23:0]      count_next;
  logic [COL_W-1:0] rd_addr;

  logic             nb_valid;
  logic             nb_last;
  logic [PIX_W-1:0] nb_taps [9];
  logic             nb_adv;
  logic             out_valid;
  pixel_out_t       result_q;
  logic [7:0]       filtered [4];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 13'd1;
      image_height  <= 13'd1;
      channel_count <= 3'd3;
      kernel_select <= KERN_IDENTITY;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[2:0];
        REG_KERNEL_SELECT: kernel_select <= cfg_data[2:0];
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = 13'd1;
    end else if (image_height > HEIGHT_LIMIT) begin
      eff_h = HEIGHT_LIMIT;
    end else begin
      eff_h = image_height;
    end
  end

  assign accept   = pixel_valid && !pixel_stall;
  assign a_pix    = fwd ? fwd_above : rd_above;
  assign b_pix    = fwd ? fwd_current : rd_current;
  assign in_chans = {pixel.chan3, pixel.chan2, pixel.chan1, pixel.chan0};

  always_comb begin
    if (in_row < eff_h) begin
      v_pix = pixel.drain ? '0 : in_chans[PIX_W-1:0];
    end else begin
      v_pix = b_pix;
    end
    top_pix   = (in_row == 13'd1) ? b_pix : a_pix;
    newcol[0] = top_pix;
    newcol[1] = b_pix;
    newcol[2] = v_pix;
    emit = (in_row >= 13'd2) || ((in_row == 13'd1) && (in_column != '0));

    // neighborhood with left and right edges replicated
    for (int r = 0; r < 3; r++) begin
      if (in_column == '0) begin
        nb[r*3]     = (eff_w == WW'(1)) ? win[r*3+2] : win[r*3+1];
        nb[r*3+1]   = win[r*3+2];
        nb[r*3+2]   = win[r*3+2];
      end else begin
        nb[r*3]     = (in_column == COL_W'(1)) ? win[r*3+2] : win[r*3+1];
        nb[r*3+1]   = win[r*3+2];
        nb[r*3+2]   = newcol[r];
      end
    end

    total     = TOT_W'(eff_w) * TOT_W'(eff_h);
    count_inc = TOT_W'(out_count) + TOT_W'(1);
    last      = emit && (count_inc >= total);
    col_inc   = WW'(in_column) + WW'(1);
    col_wrap  = col_inc >= eff_w;

    if (last || col_wrap) begin
      col_next = '0;
    end else begin
      col_next = col_inc[COL_W-1:0];
    end
    if (last) begin
      row_next = '0;
    end else if (col_wrap && (in_row < ROW_LIMIT)) begin
      row_next = in_row + 13'd1;
    end else begin
      row_next = in_row;
    end
    count_next = last ? 24'd0 : count_inc[23:0];

    if (rst) begin
      rd_addr = '0;
    end else if (accept) begin
      rd_addr = col_next;
    end else begin
      rd_addr = in_column;
    end
  end

  // line stores
  always_ff @(posedge clk) begin
    if (accept) begin
      above_mem[in_column]   <= b_pix;
      current_mem[in_column] <= v_pix;
    end
    rd_above    <= above_mem[rd_addr];
    rd_current  <= current_mem[rd_addr];
    fwd_above   <= b_pix;
    fwd_current <= v_pix;
  end

  assign nb_adv      = nb_valid && (!out_valid || !result_stall);
  assign pixel_stall = nb_valid && !nb_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      out_count <= '0;
      fwd       <= 1'b0;
      nb_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      fwd <= accept && (col_next == in_column);
      if (accept) begin
        in_column <= col_next;
        in_row    <= row_next;
        if (emit) begin
          out_count <= count_next;
        end
        for (int r = 0; r < 3; r++) begin
          win[r*3]   <= win[r*3+1];
          win[r*3+1] <= win[r*3+2];
          win[r*3+2] <= newcol[r];
        end
      end
      if (accept && emit) begin
        nb_valid <= 1'b1;
      end else if (nb_adv) begin
        nb_valid <= 1'b0;
      end
      if (nb_adv) begin
        out_valid <= 1'b1;
      end else if (!result_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      nb_last <= last;
      for (int i = 0; i < 9; i++) begin
        nb_taps[i] <= nb[i];
      end
    end
  end

  always_comb begin
    taps_t       tp;
    logic [31:0] wide;
    for (int ch = 0; ch < 4; ch++) begin
      for (int i = 0; i < 9; i++) begin
        wide  = 32'(nb_taps[i]);
        tp[i] = wide[8*ch +: 8];
      end
      if ((3'(ch) < channel_count) && (ch < MAX_CHANNELS)) begin
        filtered[ch] = filter_tap(kernel_select, tp);
      end else begin
        filtered[ch] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nb_adv) begin
      result_q.out0      <= filtered[0];
      result_q.out1      <= filtered[1];
      result_q.out2      <= filtered[2];
      result_q.out3      <= filtered[3];
      result_q.frame_end <= nb_last;
    end
  end

  assign result_valid = out_valid;
  assign result       = result_q;

endmodule

@@ src/ic3_checker.sv @@
// port-level checks for image_convolution_3x3_core, attached by bind
// uses ic3_pkg types
module ic3_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       pixel_valid,
  input logic                       pixel_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input ic3_pkg::pixel_out_t        result
);

  logic       in_accept;

  assign in_accept     = pixel_valid && !pixel_stall;

  // stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // input back-pressure only comes from a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid && result_stall)
    else $error("input stalled without output back-pressure");

  // a new result needs an input transaction that passed the neighborhood and output registers
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(in_accept, 2))
    else $error("result appeared without a source transaction");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !pixel_stall)
    else $error("pipeline not empty after reset");

endmodule

bind image_convolution_3x3_core ic3_checker u_ic3_checker (.*);
